// File: rtl/smalu_pkg.sv
// package: operation codes, status codes and defaults for the stack machine alu
package smalu_pkg;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_WORD_WIDTH = 32;
  localparam int OP_W = 4;
  localparam int IMM_W = 32;
  localparam int DEPTH_W = 7;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_CONST = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV = 4'd4;
  localparam logic [OP_W-1:0] OP_MAX = 4'd5;
  localparam logic [OP_W-1:0] OP_MIN = 4'd6;
  localparam logic [OP_W-1:0] OP_NEG = 4'd7;
  localparam logic [OP_W-1:0] OP_DUP = 4'd8;
  localparam logic [OP_W-1:0] OP_SWAP = 4'd9;
  localparam logic [OP_W-1:0] OP_END = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd3;

  // decoded instruction class handed from front to back
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [IMM_W-1:0] imm;
    logic binary;
    logic push;
  } smalu_cmd_t;
endpackage

// File: rtl/smalu_front.sv
// front end: instruction intake, classification and a two-entry command queue
module smalu_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [smalu_pkg::OP_W-1:0] operation,
  input  logic signed [smalu_pkg::IMM_W-1:0] immediate,
  output logic full,
  output logic cmd_valid,
  output smalu_pkg::smalu_cmd_t cmd,
  input  logic cmd_take
);
  import smalu_pkg::*;

  smalu_cmd_t q [2];
  logic [1:0] count;
  logic rd_ptr;
  logic wr_ptr;
  logic push_in;
  smalu_cmd_t in_cmd;

  assign full = (count == 2'd2);
  assign push_in = start && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  always_comb begin
    in_cmd.op = operation;
    in_cmd.imm = immediate;
    in_cmd.binary = (operation >= OP_ADD) && (operation <= OP_MIN);
    in_cmd.push = (operation == OP_CONST) || (operation == OP_DUP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push_in) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_in} - {1'b0, cmd_take};
    end
  end

  always_ff @(posedge clk) begin
    if (push_in) begin
      q[wr_ptr] <= in_cmd;
    end
  end
endmodule

// File: rtl/smalu_div.sv
// iterative restoring divider, one quotient bit per cycle, truncating signed
module smalu_div #(
  parameter int WORD_WIDTH = smalu_pkg::DEF_WORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  output logic ready,
  output logic [WORD_WIDTH-1:0] quotient
);
  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic busy_r;
  logic [CW-1:0] cnt;
  logic [WORD_WIDTH-1:0] rem;
  logic [WORD_WIDTH-1:0] quo;
  logic [WORD_WIDTH-1:0] dvs;
  logic neg_q;
  logic [WORD_WIDTH:0] trial;
  logic [WORD_WIDTH-1:0] shifted;

  assign shifted = {rem[WORD_WIDTH-2:0], quo[WORD_WIDTH-1]};
  assign trial = {rem, quo[WORD_WIDTH-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      ready <= 1'b0;
      cnt <= '0;
    end else begin
      ready <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt <= CW'(WORD_WIDTH);
      end else if (busy_r) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy_r <= 1'b0;
          ready <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend[WORD_WIDTH-1] ? -dividend : dividend;
      dvs <= divisor[WORD_WIDTH-1] ? -divisor : divisor;
      neg_q <= dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
    end else if (busy_r) begin
      if (!trial[WORD_WIDTH]) begin
        rem <= trial[WORD_WIDTH-1:0];
        quo <= {quo[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WORD_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg_q ? -quo : quo;
endmodule

// File: rtl/smalu_ram.sv
// generic ram with one write port and one registered read port
module smalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/smalu_back.sv
// back end: stack with top two entries in registers, alu, multiplier, divider and result strobe
module smalu_back #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int WORD_WIDTH = smalu_pkg::DEF_WORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  smalu_pkg::smalu_cmd_t cmd,
  output logic cmd_take,
  output logic valid,
  output logic signed [smalu_pkg::IMM_W-1:0] top_value,
  output logic [smalu_pkg::DEPTH_W-1:0] depth,
  output logic [smalu_pkg::STATUS_W-1:0] status,
  output logic done_res
);
  import smalu_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [CW-1:0] cnt;
  logic [WORD_WIDTH-1:0] top_r;
  logic [WORD_WIDTH-1:0] nxt_r;
  smalu_cmd_t cur;

  // entries below the top two live in ram; ram[i] holds stack entry i
  logic we;
  logic [AW-1:0] waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [WORD_WIDTH-1:0] rdata;

  logic div_go;
  logic div_ready;
  logic [WORD_WIDTH-1:0] quotient;

  logic under;
  logic over;
  logic [WORD_WIDTH-1:0] alu;
  logic t_gt;

  smalu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  smalu_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(top_r), .divisor(nxt_r),
    .ready(div_ready), .quotient(quotient)
  );

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign t_gt = $signed(top_r) > $signed(nxt_r);
  // ram address of entry count-3, the one that becomes next after a pop
  assign raddr = (cnt >= CW'(3)) ? AW'(cnt - CW'(3)) : '0;

  always_comb begin
    under = 1'b0;
    over = 1'b0;
    if (cur.binary || cur.op == OP_SWAP) begin
      under = cnt < CW'(2);
    end else if (cur.op == OP_NEG || cur.op == OP_END) begin
      under = cnt < CW'(1);
    end else if (cur.push) begin
      over = cnt >= CW'(STACK_DEPTH);
    end
  end

  always_comb begin
    unique case (cur.op)
      OP_ADD: alu = top_r + nxt_r;
      OP_SUB: alu = top_r - nxt_r;
      OP_MAX: alu = t_gt ? top_r : nxt_r;
      OP_MIN: alu = t_gt ? nxt_r : top_r;
      default: alu = top_r;
    endcase
  end

  always_comb begin
    state_next = state;
    div_go = 1'b0;
    we = 1'b0;
    waddr = AW'(cnt - CW'(2));
    wdata = nxt_r;
    unique case (state)
      S_IDLE: if (cmd_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (under || over) begin
          state_next = S_IDLE;
        end else if (cur.op == OP_DIV && nxt_r == '0) begin
          state_next = S_IDLE;
        end else if (cur.op == OP_DIV) begin
          div_go = 1'b1;
          state_next = S_DIV;
        end else if (cur.push) begin
          we = cnt >= CW'(2);
          state_next = S_IDLE;
        end else if (cur.binary && cur.op != OP_MUL) begin
          state_next = (cnt >= CW'(3)) ? S_FILL : S_IDLE;
        end else if (cur.op == OP_MUL) begin
          state_next = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: if (cur.op == OP_MUL || div_ready) state_next = (cnt >= CW'(3)) ? S_FILL : S_IDLE;
      S_FILL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic [WORD_WIDTH-1:0] prod;
  logic [WORD_WIDTH-1:0] res_w;

  always_ff @(posedge clk) begin
    if (state == S_EXEC) prod <= top_r * nxt_r;
  end

  assign res_w = (cur.op == OP_MUL) ? prod : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= CW'(1);
      top_r <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= 1'b0;
      unique case (state)
        S_EXEC: begin
          if (under || over || (cur.op == OP_DIV && nxt_r == '0)) begin
            valid <= 1'b1;
            status <= under ? ST_UNDER : (over ? ST_OVER : ST_DIVZ);
            top_value <= IMM_W'($signed(top_r));
            depth <= DEPTH_W'(cnt);
            done_res <= cur.op == OP_END;
          end else if (cur.op == OP_DIV || cur.op == OP_MUL) begin
          end else begin
            status <= ST_OK;
            done_res <= cur.op == OP_END;
            if (cur.push) begin
              nxt_r <= top_r;
              top_r <= (cur.op == OP_CONST) ? WORD_WIDTH'($signed(cur.imm)) : top_r;
              cnt <= cnt + 1'b1;
            end else if (cur.binary) begin
              top_r <= alu;
              cnt <= cnt - 1'b1;
            end else if (cur.op == OP_NEG) begin
              top_r <= -top_r;
            end else if (cur.op == OP_SWAP) begin
              top_r <= nxt_r;
              nxt_r <= top_r;
            end
            if (!(cur.binary && cnt >= CW'(3))) begin
              valid <= 1'b1;
              top_value <= IMM_W'($signed(
                cur.push ? ((cur.op == OP_CONST) ? WORD_WIDTH'($signed(cur.imm)) : top_r) :
                cur.binary ? alu : (cur.op == OP_NEG) ? -top_r :
                (cur.op == OP_SWAP) ? nxt_r : top_r));
              depth <= DEPTH_W'(cur.push ? cnt + 1'b1 : cur.binary ? cnt - 1'b1 : cnt);
            end
          end
        end
        S_DIV: begin
          if (cur.op == OP_MUL || div_ready) begin
            status <= ST_OK;
            done_res <= 1'b0;
            top_r <= res_w;
            cnt <= cnt - 1'b1;
            if (cnt < CW'(3)) begin
              valid <= 1'b1;
              top_value <= IMM_W'($signed(res_w));
              depth <= DEPTH_W'(cnt - 1'b1);
            end
          end
        end
        S_FILL: begin
          // ram read of the new next entry has landed
          nxt_r <= rdata;
          valid <= 1'b1;
          top_value <= IMM_W'($signed(top_r));
          depth <= DEPTH_W'(cnt);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
  end
endmodule

// File: rtl/stack_machine_alu_core.sv
// top level: stack machine alu with decoupled decode front and execute back
// usage:
//   an instruction beat (operation, immediate) is taken on a clock edge where
//   start is high and busy is low. busy rises only when the two-entry command
//   queue between the front and the back end is full.
//   each instruction gives exactly one result beat: valid is high for one
//   cycle with top_value, depth, status and done_res. the receiver cannot stall
//   and must take the beat in that cycle.
// sequencing:
//   const, dup, neg, swap, end and errors: result from the execute state.
//   add, sub, max, min: from the execute state, or from a fill state when
//   an entry must be fetched from the stack ram into the second-of-stack
//   register after the pop. mul: a further state for the registered product.
//   div: a further state that waits for the bit-serial divider.
//   the back end takes a new command only in its idle state, after the last
//   one is through its execute loop and any fill from the single ram read port.
// reset:
//   rst is synchronous; the stack holds one zero word and the queue is empty.
//   ram entries below the cached top two are undefined until written.
module stack_machine_alu_core #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int WORD_WIDTH = smalu_pkg::DEF_WORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [smalu_pkg::OP_W-1:0] operation,
  input  logic signed [smalu_pkg::IMM_W-1:0] immediate,
  output logic valid,
  output logic signed [smalu_pkg::IMM_W-1:0] top_value,
  output logic [smalu_pkg::DEPTH_W-1:0] depth,
  output logic [smalu_pkg::STATUS_W-1:0] status,
  output logic done_res
);
  import smalu_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  smalu_cmd_t cmd;

  // front: decode and queue
  smalu_front u_front (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .immediate(immediate), .full(busy), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take)
  );

  // back: stack, alu, divider
  smalu_back #(.STACK_DEPTH(STACK_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .valid(valid), .top_value(top_value), .depth(depth), .status(status),
    .done_res(done_res)
  );

  // stack never empties and never exceeds its size
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (depth != '0) && (depth <= DEPTH_W'(STACK_DEPTH)))
    else $error("depth out of range");

  // an error leaves the depth alone, so overflow reports a full stack
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_OVER |-> depth == DEPTH_W'(STACK_DEPTH))
    else $error("overflow on a stack that is not full");

  // a result never comes in back-to-back cycles
  a_gap: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("results too close");
endmodule
